@@ hw/rtl/ecs_pkg.sv @@
// ----------------------------------------------------------------------------
// ecs_pkg
// Shared beat types, character codes and constant expansion strings for the
// expression comment stripper.
// ----------------------------------------------------------------------------
package ecs_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       last_of_run;
    logic       text_done;
  } out_beat_t;

  typedef enum logic [1:0] {
    CST_NONE,
    CST_PI,
    CST_E,
    CST_PHI
  } cst_t;

  // byte burst produced by one input beat: up to four literal bytes or one
  // constant expansion
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      nbytes;
    cst_t            cst;
    logic            has_char;
    logic            eot;
  } burst_t;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_P  = 8'h70;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_I  = 8'h69;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CASE_BIT  = 8'h20;

  localparam int PI_LEN  = 17;
  localparam int E_LEN   = 10;
  localparam int PHI_LEN = 10;

  localparam logic [8*PI_LEN-1:0]  PI_STR  = "3.141592653589793";
  localparam logic [8*E_LEN-1:0]   E_STR   = "2.71828183";
  localparam logic [8*PHI_LEN-1:0] PHI_STR = "1.61803399";

  function automatic logic [4:0] const_len(cst_t sel);
    logic [4:0] len;
    len = '0;
    case (sel)
      CST_PI:  len = 5'(PI_LEN);
      CST_E:   len = 5'(E_LEN);
      CST_PHI: len = 5'(PHI_LEN);
      default: len = '0;
    endcase
    return len;
  endfunction

  // first character of each string sits in the top byte
  function automatic logic [7:0] const_char(cst_t sel, logic [4:0] idx);
    logic [7:0] ch;
    ch = '0;
    case (sel)
      CST_PI:  if (idx < 5'(PI_LEN))  ch = PI_STR[8*(PI_LEN-1-int'(idx)) +: 8];
      CST_E:   if (idx < 5'(E_LEN))   ch = E_STR[8*(E_LEN-1-int'(idx)) +: 8];
      CST_PHI: if (idx < 5'(PHI_LEN)) ch = PHI_STR[8*(PHI_LEN-1-int'(idx)) +: 8];
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

@@ hw/rtl/ecs_scanner.sv @@
// ----------------------------------------------------------------------------
// ecs_scanner
// Lexical scan state machine: turns one source byte into a byte burst and
// advances the scan mode when the beat is consumed.
// ----------------------------------------------------------------------------
module ecs_scanner (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  ecs_pkg::in_beat_t beat,
  output ecs_pkg::burst_t  burst
);

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLOCK,
    MODE_BSTAR,
    MODE_DOLLAR,
    MODE_DP,
    MODE_DPH
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_p_r, held_p_nxt;
  logic [7:0] held_h_r, held_h_nxt;

  logic [7:0]      c;
  logic [7:0]      lc;
  logic            do_plain;
  logic [2:0]      cnt;
  logic [3:0][7:0] bytes;
  ecs_pkg::cst_t   cst;
  logic            has_char;

  assign c  = beat.in_char;
  assign lc = c | ecs_pkg::CASE_BIT;

  always_comb begin
    mode_nxt   = mode_r;
    held_p_nxt = held_p_r;
    held_h_nxt = held_h_r;
    do_plain   = 1'b0;
    cnt        = '0;
    bytes      = '0;
    cst        = ecs_pkg::CST_NONE;
    has_char   = 1'b1;

    unique case (mode_r)
      MODE_NORMAL: begin
        do_plain = 1'b1;
      end
      MODE_SLASH: begin
        if (c == ecs_pkg::CH_SLASH) begin
          mode_nxt = MODE_LINE;
        end else if (c == ecs_pkg::CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          bytes[cnt[1:0]] = ecs_pkg::CH_SLASH;
          cnt = cnt + 3'd1;
          do_plain = 1'b1;
        end
      end
      MODE_LINE: begin
        if (c == ecs_pkg::CH_CR || c == ecs_pkg::CH_LF) begin
          bytes[cnt[1:0]] = ecs_pkg::CH_SPACE;
          cnt = cnt + 3'd1;
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_BLOCK: begin
        if (c == ecs_pkg::CH_STAR) mode_nxt = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        if (c == ecs_pkg::CH_SLASH) begin
          mode_nxt = MODE_NORMAL;
        end else if (c != ecs_pkg::CH_STAR) begin
          mode_nxt = MODE_BLOCK;
        end
      end
      MODE_DOLLAR: begin
        if (lc == ecs_pkg::CH_LOW_P) begin
          held_p_nxt = c;
          mode_nxt = MODE_DP;
        end else if (lc == ecs_pkg::CH_LOW_E) begin
          cst = ecs_pkg::CST_E;
          mode_nxt = MODE_NORMAL;
        end else begin
          bytes[cnt[1:0]] = ecs_pkg::CH_DOLLAR;
          cnt = cnt + 3'd1;
          do_plain = 1'b1;
        end
      end
      MODE_DP: begin
        if (lc == ecs_pkg::CH_LOW_I) begin
          cst = ecs_pkg::CST_PI;
          mode_nxt = MODE_NORMAL;
        end else if (lc == ecs_pkg::CH_LOW_H) begin
          held_h_nxt = c;
          mode_nxt = MODE_DPH;
        end else begin
          bytes[cnt[1:0]] = ecs_pkg::CH_DOLLAR;
          cnt = cnt + 3'd1;
          bytes[cnt[1:0]] = held_p_r;
          cnt = cnt + 3'd1;
          do_plain = 1'b1;
        end
      end
      MODE_DPH: begin
        if (lc == ecs_pkg::CH_LOW_I) begin
          cst = ecs_pkg::CST_PHI;
          mode_nxt = MODE_NORMAL;
        end else begin
          bytes[cnt[1:0]] = ecs_pkg::CH_DOLLAR;
          cnt = cnt + 3'd1;
          bytes[cnt[1:0]] = held_p_r;
          cnt = cnt + 3'd1;
          bytes[cnt[1:0]] = held_h_r;
          cnt = cnt + 3'd1;
          do_plain = 1'b1;
        end
      end
    endcase

    // the byte that broke a match, or any byte in normal mode
    if (do_plain) begin
      mode_nxt = MODE_NORMAL;
      if (c == ecs_pkg::CH_SLASH) begin
        mode_nxt = MODE_SLASH;
      end else if (c == ecs_pkg::CH_DOLLAR) begin
        mode_nxt = MODE_DOLLAR;
      end else if (c == ecs_pkg::CH_CR || c == ecs_pkg::CH_LF || c == ecs_pkg::CH_TAB) begin
        bytes[cnt[1:0]] = ecs_pkg::CH_SPACE;
        cnt = cnt + 3'd1;
      end else begin
        bytes[cnt[1:0]] = c;
        cnt = cnt + 3'd1;
      end
    end

    // end of text flushes a pending partial match
    if (beat.end_of_text) begin
      case (mode_nxt)
        MODE_SLASH: begin
          bytes[cnt[1:0]] = ecs_pkg::CH_SLASH;
          cnt = cnt + 3'd1;
        end
        MODE_DOLLAR: begin
          bytes[cnt[1:0]] = ecs_pkg::CH_DOLLAR;
          cnt = cnt + 3'd1;
        end
        MODE_DP: begin
          bytes[cnt[1:0]] = ecs_pkg::CH_DOLLAR;
          cnt = cnt + 3'd1;
          bytes[cnt[1:0]] = held_p_nxt;
          cnt = cnt + 3'd1;
        end
        MODE_DPH: begin
          bytes[cnt[1:0]] = ecs_pkg::CH_DOLLAR;
          cnt = cnt + 3'd1;
          bytes[cnt[1:0]] = held_p_nxt;
          cnt = cnt + 3'd1;
          bytes[cnt[1:0]] = held_h_nxt;
          cnt = cnt + 3'd1;
        end
        default: begin
        end
      endcase
      mode_nxt = MODE_NORMAL;
      // empty end marker
      if (cnt == 3'd0 && cst == ecs_pkg::CST_NONE) begin
        cnt = 3'd1;
        bytes[0] = '0;
        has_char = 1'b0;
      end
    end

    burst.bytes    = bytes;
    burst.nbytes   = cnt;
    burst.cst      = cst;
    burst.has_char = has_char;
    burst.eot      = beat.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
    end else if (step) begin
      mode_r   <= mode_nxt;
      held_p_r <= held_p_nxt;
      held_h_r <= held_h_nxt;
    end
  end

endmodule

@@ hw/rtl/expression_comment_stripper_unit.sv @@
// ----------------------------------------------------------------------------
// expression_comment_stripper_unit
// Strips line and block comments, maps CR/LF/TAB to space and expands $PI,
// $E and $PHI in a byte stream of expression text.
// Path: input register, byte emitter, output register, in that order.
// Throughput: one input beat per cycle while each beat yields at most one
// byte and out_stall is low; an n-byte beat holds the byte emitter until
// all n bytes are out (up to 17 for $PI), beats yielding nothing never wait.
// Reset: synchronous active-low rst_n empties all stages, scan mode normal.
// ----------------------------------------------------------------------------
module expression_comment_stripper_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ecs_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output ecs_pkg::out_beat_t out_beat
);

  // input register
  logic              in_valid_r;
  ecs_pkg::in_beat_t in_beat_r;

  // byte emitter
  logic            burst_valid_r;
  ecs_pkg::burst_t burst_r;
  logic [4:0]      idx_r;
  logic [4:0]      total_r;

  // output register
  logic               out_valid_r;
  ecs_pkg::out_beat_t out_beat_r;

  ecs_pkg::burst_t desc;
  logic [4:0]      total;
  logic            needs_burst;
  logic            step;
  logic            out_load;
  logic            burst_pop;
  logic            burst_last;
  logic            burst_free;
  logic            in_accept;
  logic [7:0]      cur_char;

  ecs_scanner u_scanner (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .beat  (in_beat_r),
    .burst (desc)
  );

  assign total = (desc.cst != ecs_pkg::CST_NONE) ? ecs_pkg::const_len(desc.cst)
                                                 : {2'b00, desc.nbytes};
  assign needs_burst = (total != 5'd0);

  assign out_load   = !out_valid_r || !out_stall;
  assign burst_last = (idx_r == 5'(total_r - 5'd1));
  assign burst_pop  = burst_valid_r && out_load;
  assign burst_free = !burst_valid_r || (burst_pop && burst_last);
  // beats that emit nothing only update the scan mode
  assign step       = in_valid_r && (!needs_burst || burst_free);
  assign in_stall   = in_valid_r && !step;
  assign in_accept  = in_valid && !in_stall;

  assign cur_char = (burst_r.cst != ecs_pkg::CST_NONE)
                    ? ecs_pkg::const_char(burst_r.cst, idx_r)
                    : burst_r.bytes[idx_r[1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      burst_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
        in_beat_r  <= in_beat;
      end else if (step) begin
        in_valid_r <= 1'b0;
      end

      if (step && needs_burst) begin
        burst_valid_r <= 1'b1;
        burst_r       <= desc;
        total_r       <= total;
        idx_r         <= '0;
      end else if (burst_pop && burst_last) begin
        burst_valid_r <= 1'b0;
      end else if (burst_pop) begin
        idx_r <= idx_r + 5'd1;
      end

      if (out_load) begin
        out_valid_r <= burst_valid_r;
        if (burst_valid_r) begin
          out_beat_r.out_char    <= cur_char;
          out_beat_r.has_char    <= burst_r.has_char;
          out_beat_r.last_of_run <= burst_last;
          out_beat_r.text_done   <= burst_last && burst_r.eot;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    burst_valid_r |-> (idx_r < total_r))
    else $error("burst index past burst length");

  a_burst_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    burst_valid_r |-> (total_r != 5'd0))
    else $error("empty burst loaded");

  a_marker_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_beat_r.has_char) |->
      (out_beat_r.last_of_run && out_beat_r.text_done))
    else $error("end marker not flagged as final beat");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.text_done) |-> out_beat_r.last_of_run)
    else $error("text_done without last_of_run");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && burst_valid_r))
    else $error("input stalled with nothing pending");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for expression_comment_stripper_unit. Byte streams of
// expression text go in: comments, whitespace, constant names in mixed case,
// broken constant names, cut-off texts and raw noise. A scan-mode model
// predicts every output beat, and a monitor compares each accepted beat
// field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  typedef enum logic [2:0] {
    SC_TEXT,
    SC_SLASH,
    SC_LINE,
    SC_BLOCK,
    SC_BLOCK_STAR,
    SC_DOLLAR,
    SC_DOLLAR_P,
    SC_DOLLAR_PH
  } scan_t;

  typedef struct {
    ecs_pkg::in_beat_t beat;
    bit                drain_first;
  } src_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  ecs_pkg::in_beat_t  in_beat = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ecs_pkg::out_beat_t out_beat;

  src_byte_t          src_q[$];
  logic [7:0]         text_q[$];
  ecs_pkg::out_beat_t expected_q[$];
  logic [7:0]         emitted_q[$];

  scan_t      scan = SC_TEXT;
  logic [7:0] held_p = '0;
  logic [7:0] held_h = '0;

  logic in_took = 1'b0;
  int   in_gap = 0;
  int   in_calm = 0;
  int   out_hold = 0;
  int   out_calm = 0;
  int   n_errors = 0;
  int   n_bytes_in = 0;
  int   n_beats_out = 0;
  int   n_texts = 0;
  int   n_queued = 0;

  expression_comment_stripper_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  task automatic push_digits(logic [8*ecs_pkg::PI_LEN-1:0] digits, int len);
    for (int i = 0; i < len; i++) begin
      emitted_q.push_back(digits[8*(len-1-i) +: 8]);
    end
  endtask

  // byte under the plain text rules, scan is SC_TEXT on entry
  task automatic text_rule(logic [7:0] c);
    if (c == ecs_pkg::CH_SLASH) begin
      scan = SC_SLASH;
    end else if (c == ecs_pkg::CH_DOLLAR) begin
      scan = SC_DOLLAR;
    end else if (c == ecs_pkg::CH_CR || c == ecs_pkg::CH_LF || c == ecs_pkg::CH_TAB) begin
      emitted_q.push_back(ecs_pkg::CH_SPACE);
    end else begin
      emitted_q.push_back(c);
    end
  endtask

  task automatic predict_stripped(ecs_pkg::in_beat_t b);
    logic [7:0]         c;
    logic [7:0]         lc;
    ecs_pkg::out_beat_t r;
    c = b.in_char;
    lc = c | ecs_pkg::CASE_BIT;
    emitted_q.delete();
    case (scan)
      SC_TEXT: text_rule(c);
      SC_SLASH: begin
        if (c == ecs_pkg::CH_SLASH) begin
          scan = SC_LINE;
        end else if (c == ecs_pkg::CH_STAR) begin
          scan = SC_BLOCK;
        end else begin
          emitted_q.push_back(ecs_pkg::CH_SLASH);
          scan = SC_TEXT;
          text_rule(c);
        end
      end
      SC_LINE: begin
        if (c == ecs_pkg::CH_CR || c == ecs_pkg::CH_LF) begin
          emitted_q.push_back(ecs_pkg::CH_SPACE);
          scan = SC_TEXT;
        end
      end
      SC_BLOCK: begin
        if (c == ecs_pkg::CH_STAR) scan = SC_BLOCK_STAR;
      end
      SC_BLOCK_STAR: begin
        if (c == ecs_pkg::CH_SLASH) scan = SC_TEXT;
        else if (c != ecs_pkg::CH_STAR) scan = SC_BLOCK;
      end
      SC_DOLLAR: begin
        if (lc == ecs_pkg::CH_LOW_P) begin
          held_p = c;
          scan = SC_DOLLAR_P;
        end else if (lc == ecs_pkg::CH_LOW_E) begin
          push_digits(ecs_pkg::E_STR, ecs_pkg::E_LEN);
          scan = SC_TEXT;
        end else begin
          emitted_q.push_back(ecs_pkg::CH_DOLLAR);
          scan = SC_TEXT;
          text_rule(c);
        end
      end
      SC_DOLLAR_P: begin
        if (lc == ecs_pkg::CH_LOW_I) begin
          push_digits(ecs_pkg::PI_STR, ecs_pkg::PI_LEN);
          scan = SC_TEXT;
        end else if (lc == ecs_pkg::CH_LOW_H) begin
          held_h = c;
          scan = SC_DOLLAR_PH;
        end else begin
          emitted_q.push_back(ecs_pkg::CH_DOLLAR);
          emitted_q.push_back(held_p);
          scan = SC_TEXT;
          text_rule(c);
        end
      end
      default: begin
        if (lc == ecs_pkg::CH_LOW_I) begin
          push_digits(ecs_pkg::PHI_STR, ecs_pkg::PHI_LEN);
          scan = SC_TEXT;
        end else begin
          emitted_q.push_back(ecs_pkg::CH_DOLLAR);
          emitted_q.push_back(held_p);
          emitted_q.push_back(held_h);
          scan = SC_TEXT;
          text_rule(c);
        end
      end
    endcase

    if (b.end_of_text) begin
      // a half-seen opener or constant name is flushed as it came in
      case (scan)
        SC_SLASH: emitted_q.push_back(ecs_pkg::CH_SLASH);
        SC_DOLLAR: emitted_q.push_back(ecs_pkg::CH_DOLLAR);
        SC_DOLLAR_P: begin
          emitted_q.push_back(ecs_pkg::CH_DOLLAR);
          emitted_q.push_back(held_p);
        end
        SC_DOLLAR_PH: begin
          emitted_q.push_back(ecs_pkg::CH_DOLLAR);
          emitted_q.push_back(held_p);
          emitted_q.push_back(held_h);
        end
        default: ;
      endcase
      scan = SC_TEXT;
      if (emitted_q.size() == 0) begin
        r.out_char = '0;
        r.has_char = 1'b0;
        r.last_of_run = 1'b1;
        r.text_done = 1'b1;
        expected_q.push_back(r);
      end
    end

    foreach (emitted_q[k]) begin
      r.out_char = emitted_q[k];
      r.has_char = 1'b1;
      r.last_of_run = (k == emitted_q.size() - 1);
      r.text_done = r.last_of_run && b.end_of_text;
      expected_q.push_back(r);
    end
  endtask

  // ------------------------------------------------------------- stimulus

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [7:0] any_case(logic [7:0] lower);
    return $urandom_range(0, 1) ? lower : (lower & ~ecs_pkg::CASE_BIT);
  endfunction

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // hands the built text to the driver, last byte flagged as end of text
  task automatic end_text(bit drain_first);
    src_byte_t sb;
    foreach (text_q[i]) begin
      sb.beat.in_char = text_q[i];
      sb.beat.end_of_text = (i == text_q.size() - 1);
      sb.drain_first = drain_first && (i == 0);
      src_q.push_back(sb);
    end
    n_queued += text_q.size();
    n_texts++;
    text_q.delete();
  endtask

  task automatic build_text();
    int         ntok;
    int         n;
    logic [7:0] c;
    ntok = $urandom_range(1, 7);
    for (int k = 0; k < ntok; k++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n) text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        2: begin
          case ($urandom_range(0, 3))
            0: text_q.push_back(ecs_pkg::CH_CR);
            1: text_q.push_back(ecs_pkg::CH_LF);
            2: text_q.push_back(ecs_pkg::CH_TAB);
            default: text_q.push_back(ecs_pkg::CH_SPACE);
          endcase
        end
        3, 4: begin
          text_q.push_back(ecs_pkg::CH_DOLLAR);
          case ($urandom_range(0, 2))
            0: begin
              text_q.push_back(any_case(ecs_pkg::CH_LOW_P));
              text_q.push_back(any_case(ecs_pkg::CH_LOW_I));
            end
            1: text_q.push_back(any_case(ecs_pkg::CH_LOW_E));
            default: begin
              text_q.push_back(any_case(ecs_pkg::CH_LOW_P));
              text_q.push_back(any_case(ecs_pkg::CH_LOW_H));
              text_q.push_back(any_case(ecs_pkg::CH_LOW_I));
            end
          endcase
        end
        5: begin
          // constant name that breaks off, the breaking byte is random
          text_q.push_back(ecs_pkg::CH_DOLLAR);
          n = $urandom_range(0, 2);
          if (n >= 1) text_q.push_back(any_case(ecs_pkg::CH_LOW_P));
          if (n >= 2) text_q.push_back(any_case(ecs_pkg::CH_LOW_H));
          text_q.push_back(8'($urandom_range(1, 255)));
        end
        6: begin
          text_q.push_back(ecs_pkg::CH_SLASH);
          text_q.push_back(ecs_pkg::CH_SLASH);
          n = $urandom_range(0, 6);
          repeat (n) begin
            c = 8'($urandom_range(1, 255));
            text_q.push_back((c == ecs_pkg::CH_CR || c == ecs_pkg::CH_LF) ? 8'h78 : c);
          end
          text_q.push_back($urandom_range(0, 1) ? ecs_pkg::CH_CR : ecs_pkg::CH_LF);
        end
        7: begin
          text_q.push_back(ecs_pkg::CH_SLASH);
          text_q.push_back(ecs_pkg::CH_STAR);
          n = $urandom_range(0, 6);
          repeat (n) begin
            case ($urandom_range(0, 3))
              0: text_q.push_back(ecs_pkg::CH_STAR);
              1: text_q.push_back(ecs_pkg::CH_SLASH);
              default: text_q.push_back(8'($urandom_range(1, 255)));
            endcase
          end
          text_q.push_back(ecs_pkg::CH_STAR);
          text_q.push_back(ecs_pkg::CH_SLASH);
        end
        8: begin
          text_q.push_back($urandom_range(0, 1) ? ecs_pkg::CH_SLASH : ecs_pkg::CH_DOLLAR);
          text_q.push_back(8'($urandom_range(8'h21, 8'h7E)));
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
        end
      endcase
    end
    // some texts end in the middle of a comment or constant name
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(0, text_q.size() - 1);
      repeat (n) void'(text_q.pop_back());
    end
  endtask

  // --------------------------------------------------------------- driver

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (src_q.size() == 0 ||
                   (src_q[0].drain_first && expected_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        in_beat <= src_q[0].beat;
        in_valid <= 1'b1;
        void'(src_q.pop_front());
        if (in_calm > 0) begin
          in_calm <= in_calm - 1;
          in_gap <= 0;
        end else begin
          in_gap <= idle_len();
          if ($urandom_range(0, 49) == 0) in_calm <= $urandom_range(20, 80);
        end
      end
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold <= out_hold - 1;
    end else if (out_calm > 0) begin
      out_stall <= 1'b0;
      out_calm <= out_calm - 1;
    end else begin
      out_stall <= 1'b0;
      out_hold <= idle_len();
      if ($urandom_range(0, 59) == 0) out_calm <= $urandom_range(20, 80);
    end
  end

  // -------------------------------------------------------------- monitor

  task automatic report(string what, ecs_pkg::out_beat_t got, ecs_pkg::out_beat_t want);
    n_errors++;
    if (n_errors <= 30) begin
      $display("mismatch %0s @%0t: got %02h h%b l%b d%b, want %02h h%b l%b d%b",
               what, $time, got.out_char, got.has_char, got.last_of_run,
               got.text_done, want.out_char, want.has_char, want.last_of_run,
               want.text_done);
    end
  endtask

  always @(posedge clk) begin : result_check
    ecs_pkg::out_beat_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      // result beats trail their source beat, so check before predicting
      if (out_valid && !out_stall) begin
        n_beats_out++;
        if (expected_q.size() == 0) begin
          report("stray beat", out_beat, '0);
        end else begin
          want = expected_q.pop_front();
          if (out_beat.out_char !== want.out_char) report("out_char", out_beat, want);
          if (out_beat.has_char !== want.has_char) report("has_char", out_beat, want);
          if (out_beat.last_of_run !== want.last_of_run) begin
            report("last_of_run", out_beat, want);
          end
          if (out_beat.text_done !== want.text_done) report("text_done", out_beat, want);
        end
      end
      if (in_valid && !in_stall) begin
        n_bytes_in++;
        predict_stripped(in_beat);
      end
    end
  end

  // ------------------------------------------------------------ sequence

  initial begin
    // expansions, lone dollar broken by a tab
    add_str("$pI$e$");
    text_q.push_back(ecs_pkg::CH_TAB);
    end_text(1'b0);
    // $Ph broken by the lowest byte, line comment closed by CR
    add_str("$Ph");
    text_q.push_back(8'h01);
    add_str("//x");
    text_q.push_back(ecs_pkg::CH_CR);
    end_text(1'b0);
    // star of the opener must not close the block, then top byte and LF
    add_str("/*/*/");
    text_q.push_back(8'hFF);
    text_q.push_back(ecs_pkg::CH_LF);
    end_text(1'b0);
    // slash broken by dollar, $P left pending at end of text
    add_str("$PHi/$P");
    end_text(1'b1);
    // open block at end gives the empty marker
    add_str("/*");
    end_text(1'b0);

    while (n_queued < 470) begin
      build_text();
      end_text($urandom_range(0, 11) == 0);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (src_q.size() != 0 || in_valid);
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("fed %0d source bytes in %0d texts with comments and constants mixed in",
             n_bytes_in, n_texts);
    $display("compared %0d result beats, %0d mismatches", n_beats_out, n_errors);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
